/* src/multichannel_iir_direct_form_one_core_assert.svh */
// Assertion helpers for the filter core
`ifndef MULTICHANNEL_IIR_DIRECT_FORM_ONE_CORE_ASSERT_SVH
`define MULTICHANNEL_IIR_DIRECT_FORM_ONE_CORE_ASSERT_SVH

// same-cycle implication
`define IIRDF1_AST_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("iirdf1 check failed");

// next-cycle implication
`define IIRDF1_AST_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("iirdf1 check failed");

`endif

/* src/iirdf1_pkg.sv */
`timescale 1ns / 1ps
package iirdf1_pkg;

    localparam int TAP_REGS = 6;
    localparam int TAP_IW   = 3;
    localparam int CFG_IW   = 3;

    typedef logic [CFG_IW-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_ORDER = 3'd0;
    localparam t_cfg_idx CFG_DIMS  = 3'd1;
    localparam t_cfg_idx CFG_TAP0  = 3'd2;

    typedef struct packed {
        logic clear;
        logic mul_en;
        logic acc_en;
    } t_mac_ctrl;

endpackage

/* src/iirdf1_ram.sv */
`timescale 1ns / 1ps
module iirdf1_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 96,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/iirdf1_mac.sv */
`timescale 1ns / 1ps
module iirdf1_mac
    import iirdf1_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_mac_ctrl          i_ctrl,
    input  logic signed [31:0] i_op_a,
    input  logic signed [31:0] i_op_b,
    output logic [63:0]        o_sum
);

    logic signed [63:0] w_prod;
    logic [63:0]        r_prod;
    logic [63:0]        r_acc;

    assign w_prod = i_op_a * i_op_b;
    assign o_sum  = r_acc + r_prod;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_prod <= w_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_ctrl.clear) begin
            r_acc <= '0;
        end else if (i_ctrl.acc_en) begin
            r_acc <= o_sum;
        end
    end

endmodule

/* src/multichannel_iir_direct_form_one_core.sv */
`timescale 1ns / 1ps
// channel   | handshake                   | payload
// ----------+-----------------------------+------------------------------------------
// input     | i_in_valid / o_in_ready     | i_sample_in
// result    | o_out_valid / i_out_ready   | o_filtered_out, o_dimension_index, o_step_done
// config    | i_cfg_we (no wait)          | i_cfg_idx, i_cfg_data
//
// For each tap of an item, one shared 32x32 multiplier does the feedback and
// feedforward product on alternate cycles; then the drain state adds the last
// product and writes the history entry.
// After reset all MAX_DIMS*MAX_ORDER history entries (96 by default) are swept to
// zero; no item is accepted meanwhile, configuration writes are.
// A result waits in the output register; the next item is accepted meanwhile and
// its final cycle holds until the register is free.
module multichannel_iir_direct_form_one_core
    import iirdf1_pkg::*;
#(
    parameter int MAX_ORDER = 6,
    parameter int MAX_DIMS  = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  t_cfg_idx           i_cfg_idx,
    input  logic [63:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [31:0] i_sample_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_filtered_out,
    output logic [3:0]         o_dimension_index,
    output logic               o_step_done
);

`include "multichannel_iir_direct_form_one_core_assert.svh"

    localparam int DEPTH = MAX_DIMS * MAX_ORDER;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OW    = $clog2(MAX_ORDER + 1);
    localparam int DW    = $clog2(MAX_DIMS + 1);
    localparam int PW    = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int DCW   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int SW    = $clog2(2 * MAX_ORDER);

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_RUN   = 4'b0100,
        ST_DRAIN = 4'b1000
    } t_state;

    t_state      r_state, n_state;
    logic [2:0]  r_order;
    logic [4:0]  r_dims;
    logic [63:0] r_taps [TAP_REGS];
    logic [PW-1:0]  r_ring;
    logic [DCW-1:0] r_dim;
    logic [AW-1:0]  r_clr;
    logic [SW-1:0]  r_step;
    logic [PW-1:0]  r_m;
    logic [PW-1:0]  r_pos;
    logic [DCW-1:0] r_dim_cur;
    logic [AW-1:0]  r_base;
    logic           r_last;
    logic [31:0]    r_sample;
    logic           r_out_valid;
    logic [31:0]    r_out_y;
    logic [3:0]     r_out_dim;
    logic           r_out_last;

    logic [OW-1:0]  w_order;
    logic [DW-1:0]  w_dims;
    logic [PW-1:0]  w_pos_n;
    logic [DCW-1:0] w_dim_n;
    logic [AW-1:0]  w_base_n;
    logic           w_last_n;
    logic           w_in_acc;
    logic [31:0]    w_k32;
    logic           w_phase;
    logic [63:0]    w_coef;
    logic           w_last_step;
    logic           w_drain_go;
    logic [AW-1:0]  w_raddr;
    logic [AW-1:0]  w_waddr;
    logic [63:0]    w_wdata;
    logic           w_we;
    logic [63:0]    w_rdata;
    logic [63:0]    w_sum;
    logic [31:0]    w_y;
    logic [31:0]    w_op_a;
    logic [31:0]    w_op_b;
    t_mac_ctrl      w_mac;

    function automatic logic [PW-1:0] prev_slot(input logic [PW-1:0] m,
                                                input logic [OW-1:0] ord);
        if (m == '0) begin
            return PW'(32'(ord) - 32'd1);
        end
        return m - PW'(1);
    endfunction

    always_comb begin
        if (r_order == 3'd0) begin
            w_order = OW'(1);
        end else if (32'(r_order) > 32'(MAX_ORDER)) begin
            w_order = OW'(MAX_ORDER);
        end else begin
            w_order = OW'(r_order);
        end
        if (r_dims == 5'd0) begin
            w_dims = DW'(1);
        end else if (32'(r_dims) > 32'(MAX_DIMS)) begin
            w_dims = DW'(MAX_DIMS);
        end else begin
            w_dims = DW'(r_dims);
        end
    end

    assign w_pos_n  = (32'(r_ring) >= 32'(w_order)) ? '0 : r_ring;
    assign w_dim_n  = (32'(r_dim) >= 32'(w_dims)) ? '0 : r_dim;
    assign w_base_n = AW'(32'(w_dim_n) * MAX_ORDER);
    assign w_last_n = (32'(w_dim_n) + 32'd1) >= 32'(w_dims);

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;

    assign w_k32       = 32'(r_step) >> 1;
    assign w_phase     = r_step[0];
    assign w_coef      = (w_k32 < 32'(TAP_REGS)) ? r_taps[w_k32[TAP_IW-1:0]] : '0;
    assign w_last_step = (32'(r_step) == (2 * 32'(w_order) - 32'd1));
    assign w_drain_go  = (r_state == ST_DRAIN) && (!r_out_valid || i_out_ready);

    assign w_op_a = w_phase ? w_coef[31:0] : w_coef[63:32];
    assign w_op_b = w_phase ? w_rdata[31:0] : w_rdata[63:32];

    assign w_mac.clear  = w_in_acc;
    assign w_mac.mul_en = (r_state == ST_RUN);
    assign w_mac.acc_en = (r_state == ST_RUN) && (r_step != '0);

    assign w_y = w_sum[46:15];

    always_comb begin
        if (r_state == ST_IDLE) begin
            w_raddr = AW'(32'(w_base_n) + 32'(prev_slot(w_pos_n, w_order)));
        end else if (w_phase) begin
            w_raddr = AW'(32'(r_base) + 32'(prev_slot(r_m, w_order)));
        end else begin
            w_raddr = AW'(32'(r_base) + 32'(r_m));
        end
        if (r_state == ST_CLEAR) begin
            w_we    = 1'b1;
            w_waddr = r_clr;
            w_wdata = '0;
        end else begin
            w_we    = w_drain_go;
            w_waddr = AW'(32'(r_base) + 32'(r_pos));
            w_wdata = {w_y, r_sample};
        end
    end

    iirdf1_ram #(
        .WIDTH (64),
        .DEPTH (DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    iirdf1_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_mac),
        .i_op_a  (w_op_a),
        .i_op_b  (w_op_b),
        .o_sum   (w_sum)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= 3'd1;
            r_dims  <= 5'd1;
            for (int i = 0; i < TAP_REGS; i++) begin
                r_taps[i] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ORDER: r_order <= i_cfg_data[2:0];
                CFG_DIMS:  r_dims  <= i_cfg_data[4:0];
                default: begin
                    if (i_cfg_idx >= CFG_TAP0) begin
                        r_taps[TAP_IW'(i_cfg_idx - CFG_TAP0)] <= i_cfg_data;
                    end
                end
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (32'(r_clr) == 32'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (w_last_step) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (w_drain_go) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_step      <= '0;
            r_ring      <= '0;
            r_dim       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (w_in_acc) begin
                r_step <= '0;
            end else if ((r_state == ST_RUN) && !w_last_step) begin
                r_step <= r_step + SW'(1);
            end
            if (w_drain_go) begin
                if (r_last) begin
                    r_dim  <= '0;
                    r_ring <= ((32'(r_pos) + 32'd1) >= 32'(w_order)) ? '0 : r_pos + PW'(1);
                end else begin
                    r_dim  <= r_dim_cur + DCW'(1);
                    r_ring <= r_pos;
                end
            end
            if (w_drain_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_sample  <= i_sample_in;
            r_pos     <= w_pos_n;
            r_dim_cur <= w_dim_n;
            r_base    <= w_base_n;
            r_last    <= w_last_n;
            r_m       <= prev_slot(w_pos_n, w_order);
        end else if ((r_state == ST_RUN) && w_phase) begin
            r_m <= prev_slot(r_m, w_order);
        end
        if (w_drain_go) begin
            r_out_y    <= w_y;
            r_out_dim  <= 4'(32'(r_dim_cur));
            r_out_last <= r_last;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_filtered_out    = r_out_y;
    assign o_dimension_index = r_out_dim;
    assign o_step_done       = r_out_last;

    `IIRDF1_AST_NEXT(a_accept_starts_run, w_in_acc, (r_state == ST_RUN) && (r_step == '0))
    `IIRDF1_AST_NOW(a_step_in_range, r_state == ST_RUN, 32'(r_step) < 2 * 32'(w_order))
    `IIRDF1_AST_NEXT(a_drain_holds, (r_state == ST_DRAIN) && r_out_valid && !i_out_ready, r_state == ST_DRAIN)
    `IIRDF1_AST_NOW(a_no_accept_in_clear, r_state == ST_CLEAR, !o_in_ready && !o_out_valid)

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
module testbench;
    import iirdf1_pkg::*;

    localparam int MAX_ORDER = 6;
    localparam int MAX_DIMS  = 16;
    localparam int N_ITEMS   = 1150;
    localparam int N_DIR     = 37;

    localparam t_cfg_idx CFG_TAP1 = t_cfg_idx'(CFG_TAP0 + 3'd1);
    localparam t_cfg_idx CFG_TAP2 = t_cfg_idx'(CFG_TAP0 + 3'd2);
    localparam t_cfg_idx CFG_TAP3 = t_cfg_idx'(CFG_TAP0 + 3'd3);
    localparam t_cfg_idx CFG_TAP4 = t_cfg_idx'(CFG_TAP0 + 3'd4);
    localparam t_cfg_idx CFG_TAP5 = t_cfg_idx'(CFG_TAP0 + 3'd5);

    typedef struct packed {
        logic [31:0] y;
        logic [3:0]  dim;
        logic        last;
    } filt_result_t;

    typedef struct {
        logic        is_cfg;
        t_cfg_idx    idx;
        logic [63:0] data;
        logic        typed;
        logic [31:0] typed_y;
    } stim_row_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    t_cfg_idx           i_cfg_idx = CFG_ORDER;
    logic [63:0]        i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic signed [31:0] i_sample_in = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic signed [31:0] o_filtered_out;
    logic [3:0]         o_dimension_index;
    logic               o_step_done;

    // shadow of the filter: registers, per-dimension history rings, counters
    logic [2:0]  order_reg = 3'd1;
    logic [4:0]  dims_reg = 5'd1;
    logic [63:0] tap_reg [TAP_REGS];
    logic [31:0] hist_y [MAX_DIMS][MAX_ORDER];
    logic [31:0] hist_x [MAX_DIMS][MAX_ORDER];
    int unsigned ring_pos = 0;
    int unsigned dim_ctr = 0;

    filt_result_t pending_outputs[$];
    stim_row_t    dir_rows [N_DIR];
    int           mismatch_count = 0;
    int           items_sent = 0;
    int           burst_left = 0;
    logic [15:0]  ready_pat = 16'hFFFF;
    int           pat_hold = 0;

    multichannel_iir_direct_form_one_core #(
        .MAX_ORDER(MAX_ORDER),
        .MAX_DIMS (MAX_DIMS)
    ) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_sample_in      (i_sample_in),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_filtered_out   (o_filtered_out),
        .o_dimension_index(o_dimension_index),
        .o_step_done      (o_step_done)
    );

    always #10 i_clk = ~i_clk;

    function automatic filt_result_t filter_step(input logic [31:0] x);
        int unsigned ord, nd, m;
        logic [63:0] acc;
        logic [63:0] c;
        logic signed [31:0] ca, cb, hy, hx;
        longint pa, pb;
        filt_result_t r;
        ord = order_reg;
        if (ord == 0) ord = 1;
        if (ord > MAX_ORDER) ord = MAX_ORDER;
        nd = dims_reg;
        if (nd == 0) nd = 1;
        if (nd > MAX_DIMS) nd = MAX_DIMS;
        if (ring_pos >= ord) ring_pos = 0;
        if (dim_ctr >= nd) dim_ctr = 0;
        acc = '0;
        m = ring_pos;
        for (int k = 0; k < ord; k++) begin
            m = (m == 0) ? ord - 1 : m - 1;
            c = (k < TAP_REGS) ? tap_reg[k] : '0;
            ca = c[63:32];
            cb = c[31:0];
            hy = hist_y[dim_ctr][m];
            hx = hist_x[dim_ctr][m];
            pa = longint'(ca) * longint'(hy);
            pb = longint'(cb) * longint'(hx);
            acc = acc + pa + pb;
        end
        r.y = acc[46:15];
        r.dim = dim_ctr[3:0];
        r.last = (dim_ctr + 1 >= nd);
        hist_y[dim_ctr][ring_pos] = r.y;
        hist_x[dim_ctr][ring_pos] = x;
        if (r.last) begin
            dim_ctr = 0;
            ring_pos = (ring_pos + 1 >= ord) ? 0 : ring_pos + 1;
        end else begin
            dim_ctr = dim_ctr + 1;
        end
        return r;
    endfunction

    function automatic logic [31:0] rand_sample();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2, 3, 4: return {{12{r[19]}}, r[19:0]};
            default: return r;
        endcase
    endfunction

    function automatic logic [63:0] rand_taps();
        logic [31:0] a, b;
        a = $urandom;
        b = $urandom;
        case ($urandom_range(0, 7))
            0: return '0;
            1: return {($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000),
                       ($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000)};
            2: return {a, b};
            default: return {{15{a[16]}}, a[16:0], {15{b[16]}}, b[16:0]};
        endcase
    endfunction

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_outputs.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_reg(input t_cfg_idx idx, input logic [63:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_ORDER: order_reg = data[2:0];
            CFG_DIMS:  dims_reg = data[4:0];
            default:   tap_reg[idx - CFG_TAP0] = data;
        endcase
    endtask

    task automatic push_sample(input logic [31:0] x, input logic typed,
                               input logic [31:0] typed_y);
        filt_result_t r;
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_in_valid  <= 1'b1;
        i_sample_in <= x;
        do @(posedge i_clk); while (!o_in_ready);
        r = filter_step(x);
        if (typed) r.y = typed_y;
        pending_outputs.push_back(r);
        burst_left--;
        items_sent++;
    endtask

    task automatic reconfigure(input bit write_all);
        logic [63:0] v;
        bit wrote;
        wait_idle();
        wrote = 0;
        if (write_all || $urandom_range(0, 1)) begin
            v = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : '0;
            v[2:0] = 3'($urandom_range(0, 7));
            set_reg(CFG_ORDER, v);
            wrote = 1;
        end
        if (write_all || $urandom_range(0, 1)) begin
            v = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : '0;
            v[4:0] = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                                 : 5'($urandom_range(1, 4));
            set_reg(CFG_DIMS, v);
            wrote = 1;
        end
        for (int k = 0; k < TAP_REGS; k++) begin
            if (write_all || $urandom_range(0, 1)) begin
                set_reg(t_cfg_idx'(CFG_TAP0 + k), rand_taps());
                wrote = 1;
            end
        end
        if (wrote) i_cfg_we <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (pat_hold == 0) begin
            case ($urandom_range(0, 3))
                0: ready_pat = 16'hFFFF;
                1: ready_pat = 16'h8421;
                default: ready_pat = 16'($urandom) | 16'h0001;
            endcase
            pat_hold = $urandom_range(16, 96);
        end
        pat_hold--;
        i_out_ready <= ready_pat[0];
        ready_pat = {ready_pat[0], ready_pat[15:1]};
    end

    always @(posedge i_clk) begin
        filt_result_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_outputs.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: y=%h dim=%0d last=%b",
                             o_filtered_out, o_dimension_index, o_step_done);
            end else begin
                want = pending_outputs.pop_front();
                if (o_filtered_out !== want.y || o_dimension_index !== want.dim ||
                    o_step_done !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: y=%h/%h dim=%0d/%0d last=%b/%b (got/exp)",
                                 o_filtered_out, want.y, o_dimension_index, want.dim,
                                 o_step_done, want.last);
                end
            end
        end
    end

    initial begin
        int n;
        bit cfg_open;
        foreach (tap_reg[k]) tap_reg[k] = '0;
        foreach (hist_y[d, s]) begin
            hist_y[d][s] = '0;
            hist_x[d][s] = '0;
        end
        dir_rows = '{
            '{1'b0, CFG_ORDER, 64'h7FFF_FFFF,           1'b1, 32'h0000_0000},
            '{1'b0, CFG_ORDER, 64'h8000_0000,           1'b1, 32'h0000_0000},
            '{1'b1, CFG_TAP0,  64'h0000_0000_0000_8000, 1'b0, 32'h0},
            '{1'b0, CFG_ORDER, 64'h0000_0001,           1'b1, 32'h8000_0000},
            '{1'b0, CFG_ORDER, 64'h1234_5678,           1'b1, 32'h0000_0001},
            '{1'b0, CFG_ORDER, 64'hFFFF_FFFF,           1'b1, 32'h1234_5678},
            '{1'b1, CFG_TAP0,  64'h0000_8000_0000_0000, 1'b0, 32'h0},
            '{1'b0, CFG_ORDER, 64'h0000_0000,           1'b1, 32'h1234_5678},
            '{1'b1, CFG_TAP0,  64'h7FFF_FFFF_7FFF_FFFF, 1'b0, 32'h0},
            '{1'b0, CFG_ORDER, 64'h8000_0000,           1'b0, 32'h0},
            '{1'b0, CFG_ORDER, 64'h7FFF_FFFF,           1'b0, 32'h0},
            '{1'b0, CFG_ORDER, 64'h8000_0000,           1'b0, 32'h0},
            '{1'b1, CFG_TAP0,  64'h8000_0000_8000_0000, 1'b0, 32'h0},
            '{1'b0, CFG_ORDER, 64'h7FFF_FFFF,           1'b0, 32'h0},
            '{1'b0, CFG_ORDER, 64'h8000_0000,           1'b0, 32'h0},
            '{1'b1, CFG_ORDER, 64'd7,                   1'b0, 32'h0},
            '{1'b1, CFG_DIMS,  64'd0,                   1'b0, 32'h0},
            '{1'b1, CFG_TAP0,  64'h0000_4000_0000_2000, 1'b0, 32'h0},
            '{1'b1, CFG_TAP1,  64'hFFFF_C000_0000_1000, 1'b0, 32'h0},
            '{1'b1, CFG_TAP2,  64'h0000_2000_FFFF_F000, 1'b0, 32'h0},
            '{1'b1, CFG_TAP3,  64'h0000_1000_0000_0800, 1'b0, 32'h0},
            '{1'b1, CFG_TAP4,  64'hFFFF_F000_0000_0400, 1'b0, 32'h0},
            '{1'b1, CFG_TAP5,  64'h0000_0800_FFFF_FC00, 1'b0, 32'h0},
            '{1'b0, CFG_ORDER, 64'h0001_0000,           1'b0, 32'h0},
            '{1'b0, CFG_ORDER, 64'hFFFF_0000,           1'b0, 32'h0},
            '{1'b0, CFG_ORDER, 64'h0000_8000,           1'b0, 32'h0},
            '{1'b0, CFG_ORDER, 64'h7FFF_FFFF,           1'b0, 32'h0},
            '{1'b1, CFG_ORDER, 64'd2,                   1'b0, 32'h0},
            '{1'b0, CFG_ORDER, 64'h0000_4000,           1'b0, 32'h0},
            '{1'b0, CFG_ORDER, 64'h8000_0000,           1'b0, 32'h0},
            '{1'b1, CFG_ORDER, 64'd0,                   1'b0, 32'h0},
            '{1'b0, CFG_ORDER, 64'h0000_0123,           1'b0, 32'h0},
            '{1'b1, CFG_DIMS,  64'd31,                  1'b0, 32'h0},
            '{1'b0, CFG_ORDER, 64'h0000_2000,           1'b0, 32'h0},
            '{1'b0, CFG_ORDER, 64'hFFFF_E000,           1'b0, 32'h0},
            '{1'b1, CFG_DIMS,  64'd2,                   1'b0, 32'h0},
            '{1'b0, CFG_ORDER, 64'h0000_0777,           1'b0, 32'h0}
        };

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        cfg_open = 0;
        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) begin
                if (!cfg_open) begin
                    wait_idle();
                    cfg_open = 1;
                end
                set_reg(dir_rows[i].idx, dir_rows[i].data);
            end else begin
                if (cfg_open) begin
                    i_cfg_we <= 1'b0;
                    cfg_open = 0;
                end
                push_sample(dir_rows[i].data[31:0], dir_rows[i].typed, dir_rows[i].typed_y);
            end
        end

        reconfigure(1);
        while (items_sent < N_ITEMS) begin
            n = $urandom_range(4, 60);
            while (n > 0 && items_sent < N_ITEMS) begin
                push_sample(rand_sample(), 1'b0, 32'h0);
                n--;
            end
            reconfigure($urandom_range(0, 5) == 0);
        end

        wait_idle();
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
